FILE: rtl/ispe_pkg.sv
// shared types, codes and constants for the indexed sprite pixel effects core
package ispe_pkg;

   localparam logic [2:0] KIND_PIXEL  = 3'd0;
   localparam logic [2:0] KIND_START  = 3'd1;
   localparam logic [2:0] KIND_GHOST  = 3'd2;
   localparam logic [2:0] KIND_SHADOW = 3'd3;
   localparam logic [2:0] KIND_FADE   = 3'd4;

   localparam logic [1:0] CSR_EFFECT_MODE  = 2'd0;
   localparam logic [1:0] CSR_FADE_STEPS   = 2'd1;
   localparam logic [1:0] CSR_PARTIAL_STEP = 2'd2;
   localparam logic [1:0] CSR_START_PHASE  = 2'd3;

   localparam int unsigned CSR_DATA_W = 9;

   localparam logic [7:0] GHOST_ROW_NONE = 8'hFF;
   localparam logic [8:0] PARTIAL_STEP_RESET = 9'd256;

   localparam int unsigned MODE_TRANSPARENT = 0;
   localparam int unsigned MODE_GHOST       = 1;
   localparam int unsigned MODE_FADE        = 2;
   localparam int unsigned MODE_PREDATOR    = 3;
   localparam logic [3:0]  MODE_PREDATOR_ONLY = 4'b1000;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  src_pixel;
      logic [7:0]  dst_pixel;
      logic [7:0]  ahead_one;
      logic [7:0]  ahead_two;
      logic [7:0]  ahead_three;
      logic [7:0]  ahead_four;
      logic [7:0]  ahead_five;
      logic [4:0]  ahead_in_limit;
      logic [15:0] table_address;
      logic [7:0]  table_data;
   } req_type;

   typedef struct packed {
      logic [7:0] out_pixel;
      logic       write_enable;
   } rsp_type;

   typedef struct packed {
      logic load_item;
      logic exec;
      logic shadow_rd;
      logic take_shadow;
      logic fade_first;
      logic fade_next;
      logic take_fade;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic kind_pixel;
      logic skip;
      logic ghost_go;
      logic fade_go;
      logic fade_last;
   } status_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_EXEC   = 7'b0000010,
      ST_GHOST  = 7'b0000100,
      ST_SHADOW = 7'b0001000,
      ST_FSTART = 7'b0010000,
      ST_FADE   = 7'b0100000,
      ST_OUT    = 7'b1000000
   } state_type;

   // predator offset of pixel ahead, by phase
   function automatic logic [2:0] pred_offset(input logic [2:0] phase);
      logic [2:0] off;
      case (phase)
         3'd0:    off = 3'd1;
         3'd1:    off = 3'd3;
         3'd2:    off = 3'd2;
         3'd3:    off = 3'd5;
         3'd4:    off = 3'd2;
         3'd5:    off = 3'd3;
         3'd6:    off = 3'd4;
         default: off = 3'd1;
      endcase
      return off;
   endfunction

endpackage

FILE: rtl/ispe_ctrl.sv
// sequencer for item decode, table lookups, fade chain and result beat
module ispe_ctrl import ispe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (!status.kind_pixel) begin
               state_in = ST_IDLE;
            end else if (status.skip) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_GHOST;
            end
         end
         ST_GHOST: begin
            if (status.ghost_go) begin
               cmd.shadow_rd = 1'b1;
               state_in      = ST_SHADOW;
            end else begin
               state_in = ST_FSTART;
            end
         end
         ST_SHADOW: begin
            cmd.take_shadow = 1'b1;
            state_in        = ST_FSTART;
         end
         ST_FSTART: begin
            if (status.fade_go) begin
               cmd.fade_first = 1'b1;
               state_in       = ST_FADE;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_FADE: begin
            if (status.fade_last) begin
               cmd.take_fade = 1'b1;
               state_in      = ST_OUT;
            end else begin
               cmd.fade_next = 1'b1;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/ispe_dp.sv
// datapath: settings, predator state, lookup tables, working pixel and result register
module ispe_dp import ispe_pkg::*; #(
   parameter int SHADOW_ROWS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  req_type               req_data,
   input  cmd_type               cmd,
   output status_type            status,
   output rsp_type               rsp_data
);

   localparam int ROW_W        = (SHADOW_ROWS > 1) ? $clog2(SHADOW_ROWS) : 1;
   localparam int SHADOW_DEPTH = SHADOW_ROWS * 256;
   localparam logic [8:0] ROW_LIMIT = 9'(SHADOW_ROWS);

   logic [3:0] mode_ff;
   logic [5:0] fade_steps_ff;
   logic [8:0] step_ff;
   logic [2:0] start_phase_ff;

   logic [7:0] acc_ff, acc_in;
   logic [2:0] phase_ff, phase_in;
   req_type    item_ff;
   logic [7:0] val_ff, val_in;
   logic       we_ff, we_in;
   logic [5:0] cnt_ff;
   rsp_type    rsp_ff;

   logic [7:0] ghost_mem [256];
   logic [7:0] fade_mem [256];
   logic [7:0] shadow_mem [SHADOW_DEPTH];
   logic [7:0] ghost_rdata_ff, fade_rdata_ff, shadow_rdata_ff;

   logic [9:0] sum;
   logic       trig, inlim, hit;
   logic [2:0] off;
   logic [7:0] pick;
   logic       row_ok;
   logic [7:0] fade_raddr;
   logic       kind_pixel;

   // settings
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= '0;
         fade_steps_ff  <= '0;
         step_ff        <= PARTIAL_STEP_RESET;
         start_phase_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_EFFECT_MODE:  mode_ff        <= csr_data[3:0];
            CSR_FADE_STEPS:   fade_steps_ff  <= csr_data[5:0];
            CSR_PARTIAL_STEP: step_ff        <= csr_data[8:0];
            CSR_START_PHASE:  start_phase_ff <= csr_data[2:0];
            default: begin
            end
         endcase
      end
   end

   assign kind_pixel = (item_ff.kind == KIND_PIXEL);

   // predator substitution and transparency
   always_comb begin
      sum   = 10'(acc_ff) + 10'(step_ff);
      trig  = |sum[9:8];
      off   = pred_offset(phase_ff);
      inlim = item_ff.ahead_in_limit[3'(off - 3'd1)];
      case (off)
         3'd1:    pick = item_ff.ahead_one;
         3'd2:    pick = item_ff.ahead_two;
         3'd3:    pick = item_ff.ahead_three;
         3'd4:    pick = item_ff.ahead_four;
         default: pick = item_ff.ahead_five;
      endcase
      hit      = 1'b0;
      acc_in   = acc_ff;
      phase_in = phase_ff;
      val_in   = item_ff.src_pixel;
      we_in    = 1'b1;
      if (status.skip) begin
         val_in = '0;
         we_in  = 1'b0;
      end else if (mode_ff[MODE_PREDATOR]) begin
         acc_in = sum[7:0];
         if (trig) begin
            phase_in = phase_ff + 3'd2;
            if (inlim) begin
               val_in = pick;
               hit    = 1'b1;
            end
         end
         if (mode_ff == MODE_PREDATOR_ONLY && !hit) begin
            we_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         phase_ff <= '0;
      end else if (cmd.exec) begin
         if (item_ff.kind == KIND_START) begin
            acc_ff   <= '0;
            phase_ff <= start_phase_ff;
         end else if (kind_pixel) begin
            acc_ff   <= acc_in;
            phase_ff <= phase_in;
         end
      end
   end

   // table loads and registered reads
   always_ff @(posedge clock) begin
      if (cmd.exec && item_ff.kind == KIND_GHOST && item_ff.table_address[15:8] == 8'd0) begin
         ghost_mem[item_ff.table_address[7:0]] <= item_ff.table_data;
      end
      if (cmd.exec && kind_pixel) begin
         ghost_rdata_ff <= ghost_mem[val_in];
      end
   end

   assign fade_raddr = cmd.fade_first ? val_ff : fade_rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.exec && item_ff.kind == KIND_FADE && item_ff.table_address[15:8] == 8'd0) begin
         fade_mem[item_ff.table_address[7:0]] <= item_ff.table_data;
      end
      if (cmd.fade_first || cmd.fade_next) begin
         fade_rdata_ff <= fade_mem[fade_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && item_ff.kind == KIND_SHADOW
          && {1'b0, item_ff.table_address[15:8]} < ROW_LIMIT) begin
         shadow_mem[{item_ff.table_address[8 +: ROW_W], item_ff.table_address[7:0]}]
            <= item_ff.table_data;
      end
      if (cmd.shadow_rd) begin
         shadow_rdata_ff <= shadow_mem[{ghost_rdata_ff[ROW_W-1:0], item_ff.dst_pixel}];
      end
   end

   assign row_ok = (ghost_rdata_ff != GHOST_ROW_NONE) && ({1'b0, ghost_rdata_ff} < ROW_LIMIT);

   // working pixel, fade counter, item and result registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
      if (cmd.exec) begin
         val_ff <= val_in;
         we_ff  <= we_in;
      end else if (cmd.take_shadow) begin
         val_ff <= shadow_rdata_ff;
      end else if (cmd.take_fade) begin
         val_ff <= fade_rdata_ff;
      end
      if (cmd.fade_first) begin
         cnt_ff <= fade_steps_ff - 6'd1;
      end else if (cmd.fade_next) begin
         cnt_ff <= cnt_ff - 6'd1;
      end
      if (cmd.load_rsp) begin
         rsp_ff.out_pixel    <= we_ff ? val_ff : 8'd0;
         rsp_ff.write_enable <= we_ff;
      end
   end

   assign status.kind_pixel = kind_pixel;
   assign status.skip       = mode_ff[MODE_TRANSPARENT] && (item_ff.src_pixel == 8'd0);
   assign status.ghost_go   = mode_ff[MODE_GHOST] && we_ff && row_ok;
   assign status.fade_go    = mode_ff[MODE_FADE] && we_ff && (fade_steps_ff != 6'd0);
   assign status.fade_last  = (cnt_ff == 6'd0);

   assign rsp_data = rsp_ff;

endmodule

FILE: rtl/indexed_sprite_pixel_effects_core.sv
// top level of the indexed sprite pixel effects core
// Takes one beat at a time. A pixel beat goes from idle through the exec and ghost states, the
// shadow state when the ghost shadow lookup applies, the fade start state, the fade state for
// fade_steps chained fade table lookups when fading applies, and the out state, which waits for
// a free output register. A transparent pixel goes from exec straight to out; start-draw, table-load
// and unknown beats go back to idle and give no result. The result sits in an output register, so
// the next beat is taken while it waits. Tables are undefined until loaded; settings are to be
// written through the csr port while the core is idle, which the core does not check.
module indexed_sprite_pixel_effects_core import ispe_pkg::*; #(
   parameter int SHADOW_ROWS = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   ispe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ispe_dp #(
      .SHADOW_ROWS (SHADOW_ROWS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
